FILE: hw/rtl/lrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lenslet ray generator package
// Shared constants, configuration view, stage payloads and saturation helper.
// ----------------------------------------------------------------------------
package lrg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAT_BITS  = 10;
  localparam int DIST_BITS = 12;
  localparam int SEC_BITS  = 16;

  localparam int DIV_MW    = 32 + FRAC_BITS;
  localparam int DIV_NW    = DIV_MW + 1;
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int GEOM_STG  = 14;
  localparam int IDX_W     = 33 - FRAC_BITS;

  localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
  localparam logic signed [63:0] S32_MAX = 64'(Q_MAX);
  localparam logic signed [63:0] S32_MIN = 64'(Q_MIN);
  localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    MODE_CENTRE = 2'd0,
    MODE_AREA   = 2'd1,
    MODE_PUPIL  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        res_w;
    logic [15:0]        res_h;
    logic signed [31:0] size_w;
    logic signed [31:0] size_h;
    logic signed [31:0] isx;
    logic signed [31:0] isy;
    logic signed [15:0] im00;
    logic signed [15:0] im01;
    logic signed [15:0] im10;
    logic signed [15:0] im11;
    logic signed [31:0] lsx;
    logic signed [31:0] lsy;
    logic signed [15:0] lm00;
    logic signed [15:0] lm01;
    logic signed [15:0] lm10;
    logic signed [15:0] lm11;
    logic signed [15:0] foc;
    logic signed [15:0] dlcd;
    logic signed [31:0] dorg;
  } cfg_t;

  typedef struct packed {
    logic               inr;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic [16:0]        secx;
    logic [16:0]        secy;
  } geom_in_t;

  typedef struct packed {
    logic                     inr;
    logic signed [31:0]       base_x;
    logic signed [31:0]       base_y;
    logic signed [DIV_NW-1:0] na_x;
    logic signed [DIV_NW-1:0] na_y;
    logic signed [DIV_NW-1:0] nb_x;
    logic signed [DIV_NW-1:0] nb_y;
  } geom_out_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > S32_MAX) begin
      sat32 = Q_MAX;
    end else if (v < S32_MIN) begin
      sat32 = Q_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

FILE: hw/rtl/lrg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Restoring division, one quotient bit per stage, truncating toward zero and
// saturating to 32 bits; a zero divisor saturates by the numerator's sign (zero over zero gives zero).
// ----------------------------------------------------------------------------
module lrg_div (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic signed [lrg_pkg::DIV_NW-1:0]   num_i,
  input  logic signed [31:0]                  den_i,
  output logic signed [31:0]                  quo_o
);

  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] acc;
    logic [31:0] dmag;
    logic        neg;
    logic        nsgn;
    logic        nzero;
    logic        dzero;
    logic        ovf;
  } dstage_t;

  dstage_t                      st_q [lrg_pkg::DIV_STEPS+1];
  dstage_t                      st_d [lrg_pkg::DIV_STEPS+1];
  logic [lrg_pkg::DIV_MW-1:0]   nmag;
  logic [33:0]                  trial;
  logic [31:0]                  qmag;
  logic signed [31:0]           quo_d, quo_q;

  always_comb begin
    nmag = num_i[lrg_pkg::DIV_NW-1] ? lrg_pkg::DIV_MW'(-num_i) : lrg_pkg::DIV_MW'(num_i);
    st_d[0].dmag  = den_i[31] ? 32'(-den_i) : 32'(den_i);
    st_d[0].rem   = 32'(nmag[lrg_pkg::DIV_MW-1:32]);
    st_d[0].acc   = nmag[31:0];
    st_d[0].neg   = num_i[lrg_pkg::DIV_NW-1] ^ den_i[31];
    st_d[0].nsgn  = num_i[lrg_pkg::DIV_NW-1];
    st_d[0].nzero = (num_i == '0);
    st_d[0].dzero = (den_i == '0);
    st_d[0].ovf   = (32'(nmag[lrg_pkg::DIV_MW-1:32]) >= st_d[0].dmag);
    trial = '0;
    for (int k = 1; k <= lrg_pkg::DIV_STEPS; k++) begin
      st_d[k] = st_q[k-1];
      trial   = {1'b0, st_q[k-1].rem, st_q[k-1].acc[31]} - {2'b00, st_q[k-1].dmag};
      if (!trial[33]) begin
        st_d[k].rem = trial[31:0];
        st_d[k].acc = {st_q[k-1].acc[30:0], 1'b1};
      end else begin
        st_d[k].rem = {st_q[k-1].rem[30:0], st_q[k-1].acc[31]};
        st_d[k].acc = {st_q[k-1].acc[30:0], 1'b0};
      end
    end
    qmag = st_q[lrg_pkg::DIV_STEPS].acc;
    if (st_q[lrg_pkg::DIV_STEPS].dzero) begin
      if (st_q[lrg_pkg::DIV_STEPS].nzero) begin
        quo_d = '0;
      end else begin
        quo_d = st_q[lrg_pkg::DIV_STEPS].nsgn ? lrg_pkg::Q_MIN : lrg_pkg::Q_MAX;
      end
    end else if (st_q[lrg_pkg::DIV_STEPS].neg) begin
      if (st_q[lrg_pkg::DIV_STEPS].ovf || qmag > 32'h8000_0000) begin
        quo_d = lrg_pkg::Q_MIN;
      end else begin
        quo_d = $signed(-qmag);
      end
    end else begin
      if (st_q[lrg_pkg::DIV_STEPS].ovf || qmag[31]) begin
        quo_d = lrg_pkg::Q_MAX;
      end else begin
        quo_d = $signed(qmag);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q  <= st_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q;

endmodule

FILE: hw/rtl/lrg_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lenslet ray generator geometry pipeline
// Pixel to element image, lenslet index, lenslet centre and sample point,
// and the numerators of the first thin-lens divisions.
// ----------------------------------------------------------------------------
module lrg_geom (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  lrg_pkg::cfg_t      cfg_i,
  input  logic               valid_i,
  input  lrg_pkg::geom_in_t  data_i,
  output logic               valid_o,
  output lrg_pkg::geom_out_t data_o
);

  typedef struct packed {
    logic                                inr;
    logic signed [31:0]                  ax;
    logic signed [31:0]                  ay;
    logic signed [31:0]                  vx;
    logic signed [31:0]                  vy;
    logic signed [31:0]                  px;
    logic signed [31:0]                  py;
    logic signed [31:0]                  cx;
    logic signed [31:0]                  cy;
    logic signed [31:0]                  lpx;
    logic signed [31:0]                  lpy;
    logic signed [lrg_pkg::IDX_W-1:0]    idxx;
    logic signed [lrg_pkg::IDX_W-1:0]    idxy;
    logic signed [63:0]                  t0;
    logic signed [63:0]                  t1;
    logic signed [63:0]                  t2;
    logic signed [63:0]                  t3;
    lrg_pkg::geom_out_t                  o;
  } gpipe_t;

  gpipe_t                       st_q [lrg_pkg::GEOM_STG];
  gpipe_t                       st_d [lrg_pkg::GEOM_STG];
  logic [lrg_pkg::GEOM_STG-1:0] vld_q;

  function automatic logic signed [lrg_pkg::IDX_W-1:0] round_idx(
    input logic signed [31:0] v
  );
    logic signed [32:0]                mag;
    logic [32:0]                       sum;
    logic signed [lrg_pkg::IDX_W-1:0]  t;
    mag = v[31] ? -33'(v) : 33'(v);
    sum = 33'(mag) + 33'(lrg_pkg::HALF);
    t   = lrg_pkg::IDX_W'(sum >> lrg_pkg::FRAC_BITS);
    return v[31] ? -t : t;
  endfunction

  function automatic logic signed [31:0] sec_offset(input logic [16:0] sec);
    logic signed [63:0] r;
    r = $signed(64'(sec));
    r = (r <<< lrg_pkg::FRAC_BITS) >>> lrg_pkg::SEC_BITS;
    return lrg_pkg::sat32(r - lrg_pkg::HALF);
  endfunction

  always_comb begin
    st_d[0]     = '0;
    st_d[0].inr = data_i.inr;
    st_d[0].vx  = lrg_pkg::sat32(64'(data_i.qx) - lrg_pkg::HALF);
    st_d[0].vy  = lrg_pkg::sat32(lrg_pkg::HALF - 64'(data_i.qy));
    st_d[0].ax  = sec_offset(data_i.secx);
    st_d[0].ay  = sec_offset(data_i.secy);

    st_d[1]    = st_q[0];
    st_d[1].t0 = 64'(st_q[0].vx) * 64'(cfg_i.size_w);
    st_d[1].t1 = 64'(st_q[0].vy) * 64'(cfg_i.size_h);

    st_d[2]    = st_q[1];
    st_d[2].px = lrg_pkg::sat32(st_q[1].t0 >>> lrg_pkg::FRAC_BITS);
    st_d[2].py = lrg_pkg::sat32(st_q[1].t1 >>> lrg_pkg::FRAC_BITS);

    st_d[3]    = st_q[2];
    st_d[3].t0 = 64'(cfg_i.im00) * 64'(st_q[2].px);
    st_d[3].t1 = 64'(cfg_i.im01) * 64'(st_q[2].py);
    st_d[3].t2 = 64'(cfg_i.im10) * 64'(st_q[2].px);
    st_d[3].t3 = 64'(cfg_i.im11) * 64'(st_q[2].py);

    st_d[4]    = st_q[3];
    st_d[4].t0 = st_q[3].t0 + st_q[3].t1;
    st_d[4].t1 = st_q[3].t2 + st_q[3].t3;

    st_d[5]    = st_q[4];
    st_d[5].vx = lrg_pkg::sat32((st_q[4].t0 >>> lrg_pkg::MAT_BITS) + 64'(cfg_i.isx));
    st_d[5].vy = lrg_pkg::sat32((st_q[4].t1 >>> lrg_pkg::MAT_BITS) + 64'(cfg_i.isy));

    st_d[6]      = st_q[5];
    st_d[6].idxx = round_idx(st_q[5].vx);
    st_d[6].idxy = round_idx(st_q[5].vy);

    st_d[7]    = st_q[6];
    st_d[7].t0 = 64'(cfg_i.lm00) * 64'(st_q[6].idxx);
    st_d[7].t1 = 64'(cfg_i.lm01) * 64'(st_q[6].idxy);
    st_d[7].t2 = 64'(cfg_i.lm10) * 64'(st_q[6].idxx);
    st_d[7].t3 = 64'(cfg_i.lm11) * 64'(st_q[6].idxy);

    st_d[8]    = st_q[7];
    st_d[8].t0 = st_q[7].t0 + st_q[7].t1;
    st_d[8].t1 = st_q[7].t2 + st_q[7].t3;

    st_d[9]    = st_q[8];
    st_d[9].cx = lrg_pkg::sat32(((st_q[8].t0 <<< lrg_pkg::FRAC_BITS) >>> lrg_pkg::MAT_BITS)
                                + 64'(cfg_i.lsx));
    st_d[9].cy = lrg_pkg::sat32(((st_q[8].t1 <<< lrg_pkg::FRAC_BITS) >>> lrg_pkg::MAT_BITS)
                                + 64'(cfg_i.lsy));

    st_d[10]    = st_q[9];
    st_d[10].t0 = 64'(cfg_i.lm00) * 64'(st_q[9].ax);
    st_d[10].t1 = 64'(cfg_i.lm01) * 64'(st_q[9].ay);
    st_d[10].t2 = 64'(cfg_i.lm10) * 64'(st_q[9].ax);
    st_d[10].t3 = 64'(cfg_i.lm11) * 64'(st_q[9].ay);

    st_d[11]    = st_q[10];
    st_d[11].t0 = st_q[10].t0 + st_q[10].t1;
    st_d[11].t1 = st_q[10].t2 + st_q[10].t3;

    st_d[12] = st_q[11];
    if (cfg_i.mode == lrg_pkg::MODE_AREA) begin
      st_d[12].lpx = lrg_pkg::sat32((st_q[11].t0 >>> lrg_pkg::MAT_BITS) + 64'(st_q[11].cx));
      st_d[12].lpy = lrg_pkg::sat32((st_q[11].t1 >>> lrg_pkg::MAT_BITS) + 64'(st_q[11].cy));
    end else begin
      st_d[12].lpx = st_q[11].cx;
      st_d[12].lpy = st_q[11].cy;
    end

    st_d[13]          = st_q[12];
    st_d[13].o.inr    = st_q[12].inr;
    st_d[13].o.base_x = st_q[12].lpx;
    st_d[13].o.base_y = st_q[12].lpy;
    if (cfg_i.mode == lrg_pkg::MODE_PUPIL) begin
      st_d[13].o.na_x = lrg_pkg::DIV_NW'(lrg_pkg::sat32(-64'(st_q[12].cx)))
                        <<< lrg_pkg::FRAC_BITS;
      st_d[13].o.na_y = lrg_pkg::DIV_NW'(lrg_pkg::sat32(-64'(st_q[12].cy)))
                        <<< lrg_pkg::FRAC_BITS;
      st_d[13].o.nb_x = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].px) - 64'(st_q[12].cx)))
                        <<< lrg_pkg::DIST_BITS;
      st_d[13].o.nb_y = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].py) - 64'(st_q[12].cy)))
                        <<< lrg_pkg::DIST_BITS;
    end else begin
      st_d[13].o.na_x = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].px) - 64'(st_q[12].lpx)))
                        <<< lrg_pkg::DIST_BITS;
      st_d[13].o.na_y = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].py) - 64'(st_q[12].lpy)))
                        <<< lrg_pkg::DIST_BITS;
      st_d[13].o.nb_x = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].lpx) - 64'(st_q[12].cx)))
                        <<< lrg_pkg::DIST_BITS;
      st_d[13].o.nb_y = lrg_pkg::DIV_NW'(lrg_pkg::sat32(64'(st_q[12].lpy) - 64'(st_q[12].cy)))
                        <<< lrg_pkg::DIST_BITS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[lrg_pkg::GEOM_STG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = vld_q[lrg_pkg::GEOM_STG-1];
  assign data_o  = st_q[lrg_pkg::GEOM_STG-1].o;

endmodule

FILE: hw/rtl/lenslet_display_ray_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lenslet display ray generator
// Maps an LCD raster position to the viewer ray through its lenslet.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock cycle while the output is not stalled and
// returns one result beat for every input beat, in order. Each beat passes
// through four divider pipelines of 34 stages each that lie in series (pixel
// fraction, thin-lens terms, pupil solve, final slope) and the 14-stage
// geometry pipeline. A stall on the output freezes the whole pipeline
// and removes ready on the input. Configuration must only be written while no
// beat is in flight.
module lenslet_display_ray_generator_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [63:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // raster_x [31:0], raster_y [63:32], secondary_x [80:64],
  // secondary_y [97:81], zero padding [103:98]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // origin_x [31:0], origin_y [63:32], direction_x [95:64],
  // direction_y [127:96]
  output logic [127:0] m_axis_tdata,
  // ray_valid [0]
  output logic [0:0]   m_axis_tuser
);

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_RES     = 3'd1,
    REG_SIZE    = 3'd2,
    REG_ISHIFT  = 3'd3,
    REG_IORIENT = 3'd4,
    REG_LSHIFT  = 3'd5,
    REG_LORIENT = 3'd6,
    REG_DIST    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic        inr;
    logic [16:0] secx;
    logic [16:0] secy;
  } sa_t;

  typedef struct packed {
    logic               inr;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
  } sb_t;

  typedef struct packed {
    logic               inr;
    logic signed [31:0] base_x;
    logic signed [31:0] base_y;
    logic signed [31:0] ca_x;
    logic signed [31:0] ca_y;
    logic signed [31:0] den;
  } sc_t;

  typedef struct packed {
    logic               inr;
    logic signed [31:0] lp_x;
    logic signed [31:0] lp_y;
    logic signed [31:0] ca_x;
    logic signed [31:0] ca_y;
    logic signed [63:0] prod_x;
    logic signed [63:0] prod_y;
  } se_t;

  logic [1:0]  mode_q;
  logic [31:0] res_q;
  logic [63:0] size_q, ishift_q, iorient_q, lshift_q, lorient_q, dist_q;
  lrg_pkg::cfg_t cfg;

  logic en;
  logic signed [31:0] rx, ry;
  logic in_range;

  logic [lrg_pkg::DIV_LAT-1:0] va_q, vb_q, vc_q, vd_q;
  sa_t sa_q [lrg_pkg::DIV_LAT];
  sb_t sb_q [lrg_pkg::DIV_LAT];
  sc_t sc_q [lrg_pkg::DIV_LAT];
  se_t sd_q [lrg_pkg::DIV_LAT];

  logic signed [31:0] qa_x, qa_y;
  lrg_pkg::geom_in_t  g_in;
  lrg_pkg::geom_out_t g_out;
  logic               g_vld;

  logic signed [31:0] den_a, den_b;
  logic signed [31:0] qba_x, qba_y, qbb_x, qbb_y, r01, r12, rf;

  logic p1_vld_q;
  sc_t  p1_d, p1_q;
  logic signed [31:0] qc_x, qc_y;

  logic e1_vld_q;
  se_t  e1_d, e1_q;
  logic signed [31:0] qd_x, qd_y;

  logic         out_vld_q;
  logic [127:0] out_data_d, out_data_q;
  logic         out_user_d, out_user_q;
  se_t          fin;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= '0;
      res_q     <= '0;
      size_q    <= '0;
      ishift_q  <= '0;
      iorient_q <= '0;
      lshift_q  <= '0;
      lorient_q <= '0;
      dist_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:    mode_q    <= cfg_data_i[1:0];
        REG_RES:     res_q     <= cfg_data_i[31:0];
        REG_SIZE:    size_q    <= cfg_data_i;
        REG_ISHIFT:  ishift_q  <= cfg_data_i;
        REG_IORIENT: iorient_q <= cfg_data_i;
        REG_LSHIFT:  lshift_q  <= cfg_data_i;
        REG_LORIENT: lorient_q <= cfg_data_i;
        REG_DIST:    dist_q    <= cfg_data_i;
        default:     mode_q    <= mode_q;
      endcase
    end
  end

  assign cfg.mode   = mode_q;
  assign cfg.res_w  = res_q[15:0];
  assign cfg.res_h  = res_q[31:16];
  assign cfg.size_w = $signed(size_q[31:0]);
  assign cfg.size_h = $signed(size_q[63:32]);
  assign cfg.isx    = $signed(ishift_q[31:0]);
  assign cfg.isy    = $signed(ishift_q[63:32]);
  assign cfg.im00   = $signed(iorient_q[15:0]);
  assign cfg.im01   = $signed(iorient_q[31:16]);
  assign cfg.im10   = $signed(iorient_q[47:32]);
  assign cfg.im11   = $signed(iorient_q[63:48]);
  assign cfg.lsx    = $signed(lshift_q[31:0]);
  assign cfg.lsy    = $signed(lshift_q[63:32]);
  assign cfg.lm00   = $signed(lorient_q[15:0]);
  assign cfg.lm01   = $signed(lorient_q[31:16]);
  assign cfg.lm10   = $signed(lorient_q[47:32]);
  assign cfg.lm11   = $signed(lorient_q[63:48]);
  assign cfg.foc    = $signed(dist_q[15:0]);
  assign cfg.dlcd   = $signed(dist_q[31:16]);
  assign cfg.dorg   = $signed(dist_q[63:32]);

  // The whole pipeline moves whenever the output register can take a beat.
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  assign rx = $signed(s_axis_tdata[31:0]);
  assign ry = $signed(s_axis_tdata[63:32]);
  assign in_range = !rx[31] && !ry[31] &&
                    (34'(rx) <= $signed({2'b00, cfg.res_w, 16'h0000} >> (16 - lrg_pkg::FRAC_BITS))) &&
                    (34'(ry) <= $signed({2'b00, cfg.res_h, 16'h0000} >> (16 - lrg_pkg::FRAC_BITS)));

  lrg_div u_div_ax (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(rx)), .den_i ($signed({16'h0000, cfg.res_w})), .quo_o (qa_x)
  );
  lrg_div u_div_ay (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(ry)), .den_i ($signed({16'h0000, cfg.res_h})), .quo_o (qa_y)
  );

  assign g_in.inr  = sa_q[lrg_pkg::DIV_LAT-1].inr;
  assign g_in.qx   = qa_x;
  assign g_in.qy   = qa_y;
  assign g_in.secx = sa_q[lrg_pkg::DIV_LAT-1].secx;
  assign g_in.secy = sa_q[lrg_pkg::DIV_LAT-1].secy;

  lrg_geom u_geom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg),
    .valid_i (va_q[lrg_pkg::DIV_LAT-1]),
    .data_i  (g_in),
    .valid_o (g_vld),
    .data_o  (g_out)
  );

  assign den_a = (cfg.mode == lrg_pkg::MODE_PUPIL) ? cfg.dorg : 32'(cfg.dlcd);
  assign den_b = (cfg.mode == lrg_pkg::MODE_PUPIL) ? 32'(cfg.dlcd) : 32'(cfg.foc);

  lrg_div u_div_bax (
    .clk_i (clk_i), .en_i (en), .num_i (g_out.na_x), .den_i (den_a), .quo_o (qba_x)
  );
  lrg_div u_div_bay (
    .clk_i (clk_i), .en_i (en), .num_i (g_out.na_y), .den_i (den_a), .quo_o (qba_y)
  );
  lrg_div u_div_bbx (
    .clk_i (clk_i), .en_i (en), .num_i (g_out.nb_x), .den_i (den_b), .quo_o (qbb_x)
  );
  lrg_div u_div_bby (
    .clk_i (clk_i), .en_i (en), .num_i (g_out.nb_y), .den_i (den_b), .quo_o (qbb_y)
  );
  lrg_div u_div_r01 (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(1) <<< (2 * lrg_pkg::FRAC_BITS)),
    .den_i (cfg.dorg), .quo_o (r01)
  );
  lrg_div u_div_r12 (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(1) <<< (lrg_pkg::FRAC_BITS + lrg_pkg::DIST_BITS)),
    .den_i (32'(cfg.dlcd)), .quo_o (r12)
  );
  lrg_div u_div_rf (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(1) <<< (lrg_pkg::FRAC_BITS + lrg_pkg::DIST_BITS)),
    .den_i (32'(cfg.foc)), .quo_o (rf)
  );

  // Slopes for the lenslet modes, pupil numerator and denominator otherwise.
  always_comb begin
    p1_d.inr    = sb_q[lrg_pkg::DIV_LAT-1].inr;
    p1_d.base_x = sb_q[lrg_pkg::DIV_LAT-1].base_x;
    p1_d.base_y = sb_q[lrg_pkg::DIV_LAT-1].base_y;
    p1_d.den    = lrg_pkg::sat32(64'(r01) + 64'(r12) - 64'(rf));
    if (cfg.mode == lrg_pkg::MODE_PUPIL) begin
      p1_d.ca_x = lrg_pkg::sat32(64'(qba_x) + 64'(qbb_x));
      p1_d.ca_y = lrg_pkg::sat32(64'(qba_y) + 64'(qbb_y));
    end else begin
      p1_d.ca_x = lrg_pkg::sat32(64'(qba_x) - 64'(qbb_x));
      p1_d.ca_y = lrg_pkg::sat32(64'(qba_y) - 64'(qbb_y));
    end
  end

  lrg_div u_div_cx (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(p1_q.ca_x) <<< lrg_pkg::FRAC_BITS),
    .den_i (p1_q.den), .quo_o (qc_x)
  );
  lrg_div u_div_cy (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(p1_q.ca_y) <<< lrg_pkg::FRAC_BITS),
    .den_i (p1_q.den), .quo_o (qc_y)
  );

  always_comb begin
    e1_d.inr    = sc_q[lrg_pkg::DIV_LAT-1].inr;
    e1_d.ca_x   = sc_q[lrg_pkg::DIV_LAT-1].ca_x;
    e1_d.ca_y   = sc_q[lrg_pkg::DIV_LAT-1].ca_y;
    e1_d.prod_x = 64'(sc_q[lrg_pkg::DIV_LAT-1].ca_x) * 64'(cfg.dorg);
    e1_d.prod_y = 64'(sc_q[lrg_pkg::DIV_LAT-1].ca_y) * 64'(cfg.dorg);
    if (cfg.mode == lrg_pkg::MODE_PUPIL) begin
      e1_d.lp_x = lrg_pkg::sat32(64'(sc_q[lrg_pkg::DIV_LAT-1].base_x) + 64'(qc_x));
      e1_d.lp_y = lrg_pkg::sat32(64'(sc_q[lrg_pkg::DIV_LAT-1].base_y) + 64'(qc_y));
    end else begin
      e1_d.lp_x = sc_q[lrg_pkg::DIV_LAT-1].base_x;
      e1_d.lp_y = sc_q[lrg_pkg::DIV_LAT-1].base_y;
    end
  end

  lrg_div u_div_dx (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(e1_q.lp_x) <<< lrg_pkg::FRAC_BITS),
    .den_i (cfg.dorg), .quo_o (qd_x)
  );
  lrg_div u_div_dy (
    .clk_i (clk_i), .en_i (en),
    .num_i (lrg_pkg::DIV_NW'(e1_q.lp_y) <<< lrg_pkg::FRAC_BITS),
    .den_i (cfg.dorg), .quo_o (qd_y)
  );

  assign fin = sd_q[lrg_pkg::DIV_LAT-1];

  always_comb begin
    out_data_d = '0;
    out_user_d = 1'b0;
    if (fin.inr) begin
      out_user_d = 1'b1;
      case (cfg.mode)
        lrg_pkg::MODE_CENTRE, lrg_pkg::MODE_AREA: begin
          out_data_d[31:0]   = lrg_pkg::sat32(64'(fin.lp_x) -
                               64'(lrg_pkg::sat32(fin.prod_x >>> lrg_pkg::FRAC_BITS)));
          out_data_d[63:32]  = lrg_pkg::sat32(64'(fin.lp_y) -
                               64'(lrg_pkg::sat32(fin.prod_y >>> lrg_pkg::FRAC_BITS)));
          out_data_d[95:64]  = fin.ca_x;
          out_data_d[127:96] = fin.ca_y;
        end
        lrg_pkg::MODE_PUPIL: begin
          out_data_d[95:64]  = qd_x;
          out_data_d[127:96] = qd_y;
        end
        default: begin
          out_data_d = '0;
        end
      endcase
    end
  end

  // Valid bits of every section.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q      <= '0;
      vb_q      <= '0;
      vc_q      <= '0;
      vd_q      <= '0;
      p1_vld_q  <= 1'b0;
      e1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      va_q      <= {va_q[lrg_pkg::DIV_LAT-2:0], s_axis_tvalid};
      vb_q      <= {vb_q[lrg_pkg::DIV_LAT-2:0], g_vld};
      p1_vld_q  <= vb_q[lrg_pkg::DIV_LAT-1];
      vc_q      <= {vc_q[lrg_pkg::DIV_LAT-2:0], p1_vld_q};
      e1_vld_q  <= vc_q[lrg_pkg::DIV_LAT-1];
      vd_q      <= {vd_q[lrg_pkg::DIV_LAT-2:0], e1_vld_q};
      out_vld_q <= vd_q[lrg_pkg::DIV_LAT-1];
    end
  end

  // Payload that travels beside the dividers.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sa_q[0].inr  <= in_range;
      sa_q[0].secx <= s_axis_tdata[80:64];
      sa_q[0].secy <= s_axis_tdata[97:81];
      sb_q[0].inr    <= g_out.inr;
      sb_q[0].base_x <= g_out.base_x;
      sb_q[0].base_y <= g_out.base_y;
      sc_q[0] <= p1_q;
      sd_q[0] <= e1_q;
      for (int k = 1; k < lrg_pkg::DIV_LAT; k++) begin
        sa_q[k] <= sa_q[k-1];
        sb_q[k] <= sb_q[k-1];
        sc_q[k] <= sc_q[k-1];
        sd_q[k] <= sd_q[k-1];
      end
      p1_q       <= p1_d;
      e1_q       <= e1_d;
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid   = out_vld_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

endmodule
